// ----- rtl/mrle_pkg.sv -----
// shared types and character codes of the multi-state run-length pattern decoder
package mrle_pkg;

  // character codes
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LO_P    = 8'h70;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [7:0] CH_LO_Y    = 8'h79;

  // letter 'A' maps to state 1, prefix 'p' maps to 1
  localparam logic [7:0] LETTER_OFS = 8'h40;
  localparam logic [7:0] PREFIX_OFS = 8'h6f;

  // states per prefix step
  localparam logic [8:0] STATE_BASE = 9'd24;

  // output field widths and packed item width
  localparam int COL_W   = 16;
  localparam int ROW_W   = 16;
  localparam int STATE_W = 9;
  localparam int LEN_W   = 20;
  localparam int OUT_W   = 64;

  typedef struct packed {
    logic               emit;
    logic [LEN_W-1:0]   run_length;
    logic [STATE_W-1:0] cell_state;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   start_column;
  } run_t;

endpackage

// ----- rtl/mrle_core.sv -----
// decode state registers and per-byte next-state logic
module mrle_core #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    byte_in,
  output mrle_pkg::run_t run
);
  import mrle_pkg::*;

  localparam int SUM_W = ((COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS) + 1;
  localparam int MUL_W = COUNT_BITS + 4;

  logic [COORD_BITS-1:0] column_r, column_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  present_r, present_nxt;
  logic [3:0]            prefix_r, prefix_nxt;
  logic                  line_start_r, line_start_nxt;
  logic                  skip_r, skip_nxt;

  always_comb begin
    logic                  is_letter;
    logic                  do_emit;
    logic [COUNT_BITS-1:0] eff_count;
    logic                  eff_present;
    logic [COUNT_BITS-1:0] len;
    logic [8:0]            state_val;
    logic [MUL_W-1:0]      ext, prod;
    logic [SUM_W-1:0]      sum;
    logic [31:0]           col32, row32, len32;

    column_nxt     = column_r;
    row_nxt        = row_r;
    count_nxt      = count_r;
    present_nxt    = present_r;
    prefix_nxt     = prefix_r;
    line_start_nxt = line_start_r;
    skip_nxt       = skip_r;
    do_emit        = 1'b0;
    state_val      = '0;
    eff_count      = count_r;
    eff_present    = present_r;
    is_letter      = (byte_in >= CH_UP_A) && (byte_in <= CH_UP_X);
    ext            = '0;
    prod           = '0;
    sum            = '0;

    if ((byte_in == CH_CR) || (byte_in == CH_LF)) begin
      count_nxt      = '0;
      present_nxt    = 1'b0;
      prefix_nxt     = '0;
      line_start_nxt = 1'b1;
      skip_nxt       = 1'b0;
    end else begin
      line_start_nxt = 1'b0;
      if (skip_r) begin
        skip_nxt = 1'b1;
      end else if (line_start_r && ((byte_in == CH_HASH) || (byte_in == CH_LO_X))) begin
        skip_nxt = 1'b1;
      end else if ((prefix_r != '0) && is_letter) begin
        do_emit   = 1'b1;
        state_val = 9'(prefix_r) * STATE_BASE + 9'(byte_in - LETTER_OFS);
      end else begin
        // a prefix without a letter is dropped with its count
        if (prefix_r != '0) begin
          eff_count   = '0;
          eff_present = 1'b0;
          prefix_nxt  = '0;
          count_nxt   = '0;
          present_nxt = 1'b0;
        end
        if ((byte_in >= CH_ZERO) && (byte_in <= CH_NINE)) begin
          ext  = MUL_W'(eff_count);
          prod = (ext << 3) + (ext << 1) + MUL_W'(byte_in - CH_ZERO);
          if (prod[MUL_W-1:COUNT_BITS] != '0) begin
            count_nxt = '1;
          end else begin
            count_nxt = prod[COUNT_BITS-1:0];
          end
          present_nxt = 1'b1;
        end else if (byte_in == CH_DOT) begin
          do_emit   = 1'b1;
          state_val = '0;
        end else if (is_letter) begin
          do_emit   = 1'b1;
          state_val = 9'(byte_in - LETTER_OFS);
        end else if ((byte_in >= CH_LO_P) && (byte_in <= CH_LO_Y)) begin
          prefix_nxt = 4'(byte_in - PREFIX_OFS);
        end else if (byte_in == CH_DOLLAR) begin
          len         = eff_present ? eff_count : COUNT_BITS'(1);
          sum         = SUM_W'(row_r) + SUM_W'(len);
          row_nxt     = sum[COORD_BITS-1:0];
          column_nxt  = '0;
          count_nxt   = '0;
          present_nxt = 1'b0;
          prefix_nxt  = '0;
        end else begin
          count_nxt   = '0;
          present_nxt = 1'b0;
          prefix_nxt  = '0;
        end
      end
    end

    // run emission: zero count gives nothing but still clears pending
    len = eff_present ? eff_count : COUNT_BITS'(1);
    if (do_emit) begin
      count_nxt   = '0;
      present_nxt = 1'b0;
      prefix_nxt  = '0;
      if (len != '0) begin
        sum        = SUM_W'(column_r) + SUM_W'(len);
        column_nxt = sum[COORD_BITS-1:0];
      end
    end

    col32 = 32'(column_r);
    row32 = 32'(row_r);
    len32 = 32'(len);
    run.emit         = do_emit && (len != '0);
    run.start_column = col32[COL_W-1:0];
    run.row          = row32[ROW_W-1:0];
    run.cell_state   = state_val;
    run.run_length   = len32[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      row_r        <= '0;
      count_r      <= '0;
      present_r    <= 1'b0;
      prefix_r     <= '0;
      line_start_r <= 1'b1;
      skip_r       <= 1'b0;
    end else if (fire) begin
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      count_r      <= count_nxt;
      present_r    <= present_nxt;
      prefix_r     <= prefix_nxt;
      line_start_r <= line_start_nxt;
      skip_r       <= skip_nxt;
    end
  end

endmodule

// ----- rtl/multistate_rle_pattern_decoder.sv -----
// top level of the multi-state run-length pattern decoder
//
// usage:
//   in_*  : one pattern text byte per item; CR or LF ends a line, lines that
//           open with '#' or 'x' are skipped
//   out_* : one cell run per item (start column, row, state, length); a byte
//           gives at most one run, most bytes give none
// path: the accepting edge fills the input register; the byte is decoded into the
//   result register at the first later edge at which that register can take a
//   new decode, and a run it gives then appears on out_tvalid
// throughput: one byte per cycle while the result register is not stalled; the
//   decode is a single pass of counter and flag updates between the input and result registers
// stalls: while out_tready is low the result register holds its run and the
//   input register still takes one more byte; after that in_tready drops
//   until the run is taken
// reset: rst_n low empties both registers and clears the decode
//   state (column 0, row 0, no count, no prefix, at line start)
module multistate_rle_pattern_decoder #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] byte_req
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [mrle_pkg::OUT_W-1:0] out_tdata  // [15:0] start_column, [31:16] row,
                                                // [40:32] cell_state, [60:41] run_length
);
  import mrle_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // result register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic advance;  // result register can take a new decode
  logic step;     // byte in the input register is decoded this cycle
  run_t run;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  mrle_core #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (step),
    .byte_in(in_byte_r),
    .run    (run)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= run.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // pack fields from the lowest bit up, pad bits zero
  always_ff @(posedge clk) begin
    if (step && run.emit) begin
      out_data_r <= {3'b000, run.run_length, run.cell_state, run.row, run.start_column};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a byte held in the input register stays there while the result side stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("input register lost a byte during a stall");

  // every run carries a nonzero length
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[60:41] != 20'd0))
    else $error("run of zero length emitted");

  // decoded state never exceeds the highest prefixed state
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[40:32] <= 9'd264))
    else $error("cell state out of range");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

// ----- test/tb.sv -----
// self-checking testbench for the multi-state run-length pattern decoder
module tb;
  import mrle_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_BYTES = 850;
  localparam logic [19:0] COUNT_MAX = 20'hfffff;

  // receiver stall patterns, reselected each time ready_phase wraps to zero
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_SLOW
  } ready_mode_e;

  typedef struct {
    logic [COL_W-1:0]   start_column;
    logic [ROW_W-1:0]   row;
    logic [STATE_W-1:0] cell_state;
    logic [LEN_W-1:0]   run_length;
  } cell_run_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'h00;    // [7:0] byte_req
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;           // [15:0] start_column, [31:16] row,
                                         // [40:32] cell_state, [60:41] run_length

  multistate_rle_pattern_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // decoder state as the predictor sees it
  logic [COL_W-1:0] cur_col = '0;
  logic [ROW_W-1:0] cur_row = '0;
  logic [19:0]      count_val = '0;
  logic             count_seen = 1'b0;
  logic [3:0]       held_prefix = '0;
  logic             line_start = 1'b1;
  logic             in_comment = 1'b0;

  cell_run_t   expected_runs[$];
  int          bytes_sent = 0;
  int          skipped_bytes = 0;
  int          runs_checked = 0;
  int          mismatches = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  logic [5:0]  ready_phase = '0;
  ready_mode_e ready_mode = RDY_ALWAYS;

  // ---------------------------------------------------------------- predictor

  task automatic clear_pending();
    count_val = '0;
    count_seen = 1'b0;
    held_prefix = '0;
  endtask

  // a run of count 0 gives nothing and leaves the column alone
  task automatic add_run(input int st);
    logic [19:0] len;
    cell_run_t   run;
    len = count_seen ? count_val : 20'd1;
    if (len != 0) begin
      run.start_column = cur_col;
      run.row = cur_row;
      run.cell_state = st[STATE_W-1:0];
      run.run_length = len;
      expected_runs.push_back(run);
      cur_col = cur_col + len[COL_W-1:0];
    end
    clear_pending();
  endtask

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_X);
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    logic        first;
    longint      acc;
    logic [19:0] rows;
    first = line_start;
    if (b == CH_CR || b == CH_LF) begin
      clear_pending();
      line_start = 1'b1;
      in_comment = 1'b0;
      return;
    end
    line_start = 1'b0;
    if (in_comment)
      return;
    if (first && (b == CH_HASH || b == CH_LO_X)) begin
      in_comment = 1'b1;
      return;
    end
    // a prefix takes only a letter; otherwise it is dropped with its count
    if (held_prefix != 0) begin
      if (is_letter(b)) begin
        add_run(int'(STATE_BASE) * int'(held_prefix) + int'(b) - int'(LETTER_OFS));
        return;
      end
      clear_pending();
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      acc = longint'(count_val) * 10 + longint'(b) - longint'(CH_ZERO);
      if (acc > longint'(COUNT_MAX))
        acc = longint'(COUNT_MAX);
      count_val = acc[19:0];
      count_seen = 1'b1;
    end else if (b == CH_DOT) begin
      add_run(0);
    end else if (is_letter(b)) begin
      add_run(int'(b) - int'(LETTER_OFS));
    end else if (b >= CH_LO_P && b <= CH_LO_Y) begin
      held_prefix = 4'(b - PREFIX_OFS);
    end else if (b == CH_DOLLAR) begin
      rows = count_seen ? count_val : 20'd1;
      cur_row = cur_row + rows[ROW_W-1:0];
      cur_col = '0;
      clear_pending();
    end else begin
      // a count followed by a meaningless byte is dropped
      clear_pending();
    end
  endtask

  // ------------------------------------------------------------------ driving

  // called at a falling edge, returns at a falling edge; valid stays high
  // between items of one burst
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  // mostly short counts, now and then one long enough to saturate
  task automatic send_count();
    int n;
    n = ($urandom_range(0, 19) == 0) ? 7 : $urandom_range(1, 2);
    repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic send_state();
    case ($urandom_range(0, 2))
      0: send_byte(CH_DOT);
      1: send_byte(8'(CH_UP_A + $urandom_range(0, 23)));
      default: begin
        send_byte(8'(CH_LO_P + $urandom_range(0, 9)));
        send_byte(8'(CH_UP_A + $urandom_range(0, 23)));
      end
    endcase
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    ready_phase <= ready_phase + 1'b1;
    if (ready_phase == 0)
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
      default:    out_tready <= ready_phase[4];  // long on and off stretches
    endcase
  end

  // ----------------------------------------------------------------- checking

  always @(posedge clk) begin
    cell_run_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected cell run: column %0d row %0d state %0d length %0d",
               out_tdata[15:0], out_tdata[31:16], out_tdata[40:32], out_tdata[60:41]);
        mismatches++;
      end else begin
        want = expected_runs.pop_front();
        runs_checked++;
        if (out_tdata[15:0] !== want.start_column) begin
          $error("start_column: expected %0d, got %0d", want.start_column, out_tdata[15:0]);
          mismatches++;
        end
        if (out_tdata[31:16] !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, out_tdata[31:16]);
          mismatches++;
        end
        if (out_tdata[40:32] !== want.cell_state) begin
          $error("cell_state: expected %0d, got %0d", want.cell_state, out_tdata[40:32]);
          mismatches++;
        end
        if (out_tdata[60:41] !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, out_tdata[60:41]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d cell runs outstanding", expected_runs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests

  // comment lines with the lowest and highest byte inside, ended by CR and LF
  task automatic test_skipped_lines();
    send_byte(CH_LO_X);
    send_byte(8'h00);
    send_byte(CH_CR);
    send_byte(CH_HASH);
    send_byte(8'hff);
    send_byte(CH_LF);
  endtask

  // dead cell and the highest prefixed state
  task automatic test_states();
    send_text(".yX");
  endtask

  // counted prefixed run, zero count, saturated count that wraps the column
  task automatic test_counts();
    send_text("3pA0B");
    send_text("9999999A");
  endtask

  // counted, zero and plain row moves
  task automatic test_row_moves();
    send_text("2$0$$");
  endtask

  // prefix without a letter, count without a follower
  task automatic test_broken_sequences();
    send_text("pZ5!");
    send_byte(CH_LF);
  endtask

  // mostly well-formed tokens with random content, plus noise and broken ones
  task automatic test_random_pattern();
    int         pick;
    int         body;
    logic [7:0] c;
    while (bytes_sent - skipped_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 1) == 0)
          send_count();
        send_state();
      end else if (pick < 60) begin
        if ($urandom_range(0, 2) == 0)
          send_count();
        send_byte(CH_DOLLAR);
      end else if (pick < 68) begin
        send_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
      end else if (pick < 74) begin
        send_byte(CH_LF);
        send_byte(($urandom_range(0, 1) == 0) ? CH_HASH : CH_LO_X);
        body = $urandom_range(0, 6);
        repeat (body) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
          send_byte(c);
        end
        skipped_bytes += body;
        send_byte(CH_LF);
      end else if (pick < 82) begin
        if ($urandom_range(0, 2) == 0)
          send_count();
        send_byte(8'(CH_LO_P + $urandom_range(0, 9)));
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        send_count();
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_skipped_lines();
    test_states();
    test_counts();
    test_row_moves();
    test_broken_sequences();
    test_random_pattern();

    in_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    // the last bytes may still be in the two-stage pipeline
    repeat (8) @(posedge clk);

    $display("sent %0d pattern bytes, checked %0d cell runs", bytes_sent, runs_checked);
    $display("covered comment lines, counts to saturation, prefixed states, row moves, noise");
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
